// File: sv/arf_pkg.sv
// Shared constants for the ARP reply filter: frame offsets, fixed header bytes, register indexes.
package arf_pkg;

    localparam int unsigned IDX_W    = 6;
    localparam int unsigned MAC_W    = 48;
    localparam int unsigned IP_W     = 32;
    localparam int unsigned CFG_W    = 48;

    localparam logic [IDX_W-1:0] IDX_MAX      = 6'd63;
    localparam logic [IDX_W-1:0] ETYPE_AT     = 6'd12;
    localparam logic [IDX_W-1:0] ETYPE_LO_AT  = 6'd13;
    localparam logic [IDX_W-1:0] ARP_AT       = 6'd14;
    localparam logic [IDX_W-1:0] ARP_LAST     = 6'd21;
    localparam logic [IDX_W-1:0] SMAC_AT      = 6'd22;
    localparam logic [IDX_W-1:0] SMAC_LAST    = 6'd27;
    localparam logic [IDX_W-1:0] SIP_AT       = 6'd28;
    localparam logic [IDX_W-1:0] SIP_LAST     = 6'd31;
    localparam logic [IDX_W-1:0] TMAC_AT      = 6'd32;
    localparam logic [IDX_W-1:0] TMAC_LAST    = 6'd37;
    localparam logic [IDX_W-1:0] MIN_LEN_LAST = 6'd37;

    // Index of the last byte of the target MAC within the six MAC bytes.
    localparam logic [2:0] MAC_BYTE_LAST = 3'd5;
    // Index of the last byte of the sender IP within the four IP bytes.
    localparam logic [1:0] IP_BYTE_LAST  = 2'd3;

    localparam logic [7:0] ETYPE_HI = 8'h08;
    localparam logic [7:0] ETYPE_LO = 8'h06;

    // Fixed ARP reply header: Ethernet, IPv4, lengths 6 and 4, operation reply.
    localparam logic [7:0] HDR_FIXED [8] = '{
        8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
    };

    typedef enum logic [0:0] {
        REG_OWN_MAC   = 1'b0,
        REG_TARGET_IP = 1'b1
    } cfg_index_t;

endpackage

// File: sv/arp_reply_filter.sv
// ARP reply filter: checks a byte-serial Ethernet frame for an ARP reply addressed to us.
//
//  Channel   | Direction | Handshake                    | Payload
//  ----------+-----------+------------------------------+---------------------------------
//  frame     | in        | frame_valid / frame_ready    | frame_byte[7:0], frame_end
//  result    | out       | result_valid / result_ready  | reply_matched, sender_mac[47:0]
//  config    | in        | cfg_we (write only)          | cfg_index, cfg_data[47:0]
//
// One frame byte is taken every clock cycle when the result side keeps up.
// An accepted byte is held in the input register, and an end-marked byte's result is
// loaded into the result register when that byte moves on.
// Only an end-marked byte waiting on a full, stalled result register holds the input.
// Reset clears both configuration registers to zero and rearms the frame state.
module arp_reply_filter (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      frame_valid,
    output logic                      frame_ready,
    input  logic [7:0]                frame_byte,
    input  logic                      frame_end,

    output logic                      result_valid,
    input  logic                      result_ready,
    output logic                      reply_matched,
    output logic [arf_pkg::MAC_W-1:0] sender_mac,

    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [arf_pkg::CFG_W-1:0] cfg_data
);

    // Configuration registers.
    logic [arf_pkg::MAC_W-1:0] own_mac_reg;
    logic [arf_pkg::IP_W-1:0]  target_ip_reg;

    // Input register: holds one accepted byte until the checking logic consumes it.
    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_end_reg;

    // Per-frame state.
    logic [arf_pkg::IDX_W-1:0] byte_index_reg;
    logic [arf_pkg::IDX_W-1:0] byte_index_next;
    logic                      still_ok_reg;
    logic                      still_ok_next;
    logic [arf_pkg::MAC_W-1:0] captured_mac_reg;
    logic [arf_pkg::MAC_W-1:0] captured_mac_next;

    // Result register.
    logic                      res_valid_reg;
    logic                      res_matched_reg;
    logic [arf_pkg::MAC_W-1:0] res_mac_reg;

    logic                      advance;
    logic                      byte_fits;
    logic                      frame_ok;
    logic [arf_pkg::IDX_W-1:0] idx;
    logic [arf_pkg::IDX_W-1:0] arp_off;
    logic [arf_pkg::IDX_W-1:0] sip_off;
    logic [arf_pkg::IDX_W-1:0] tmac_off;
    logic [4:0]                sip_sel;
    logic [5:0]                tmac_sel;

    // The byte in the input register moves on unless it ends a frame and the
    // result register is still holding an earlier result that is not being taken.
    assign advance     = in_valid_reg && (!in_end_reg || !res_valid_reg || result_ready);
    assign frame_ready = !in_valid_reg || advance;

    assign idx      = byte_index_reg;
    assign arp_off  = idx - arf_pkg::ARP_AT;
    assign sip_off  = idx - arf_pkg::SIP_AT;
    assign tmac_off = idx - arf_pkg::TMAC_AT;
    // Bit offsets of the wanted byte; the first wire byte is the most significant.
    assign sip_sel  = {arf_pkg::IP_BYTE_LAST - sip_off[1:0], 3'b000};
    assign tmac_sel = {arf_pkg::MAC_BYTE_LAST - tmac_off[2:0], 3'b000};

    // Check of the current byte against what its position demands.
    always_comb
    begin
        byte_fits = 1'b1;
        if (idx == arf_pkg::ETYPE_AT)
        begin
            byte_fits = (in_byte_reg == arf_pkg::ETYPE_HI);
        end
        else if (idx == arf_pkg::ETYPE_LO_AT)
        begin
            byte_fits = (in_byte_reg == arf_pkg::ETYPE_LO);
        end
        else if (idx inside {[arf_pkg::ARP_AT:arf_pkg::ARP_LAST]})
        begin
            byte_fits = (in_byte_reg == arf_pkg::HDR_FIXED[arp_off[2:0]]);
        end
        else if (idx inside {[arf_pkg::SIP_AT:arf_pkg::SIP_LAST]})
        begin
            byte_fits = (in_byte_reg == target_ip_reg[sip_sel +: 8]);
        end
        else if (idx inside {[arf_pkg::TMAC_AT:arf_pkg::TMAC_LAST]})
        begin
            byte_fits = (in_byte_reg == own_mac_reg[tmac_sel +: 8]);
        end
    end

    // Next frame state for the byte being consumed. The sender MAC is shifted
    // in a byte at a time, and the byte position saturates for long frames.
    always_comb
    begin
        still_ok_next     = still_ok_reg && byte_fits;
        captured_mac_next = captured_mac_reg;
        if (idx inside {[arf_pkg::SMAC_AT:arf_pkg::SMAC_LAST]})
        begin
            captured_mac_next = {captured_mac_reg[arf_pkg::MAC_W-9:0], in_byte_reg};
        end
        byte_index_next = (idx == arf_pkg::IDX_MAX) ? idx : idx + 1'b1;
    end

    // A frame matches only if every check passed and it reached the last target MAC byte.
    assign frame_ok = still_ok_next && (idx >= arf_pkg::MIN_LEN_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= '0;
            target_ip_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (arf_pkg::cfg_index_t'(cfg_index))
                arf_pkg::REG_OWN_MAC:   own_mac_reg   <= cfg_data[arf_pkg::MAC_W-1:0];
                arf_pkg::REG_TARGET_IP: target_ip_reg <= cfg_data[arf_pkg::IP_W-1:0];
                default:                ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_ready)
        begin
            in_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_valid)
        begin
            in_byte_reg <= frame_byte;
            in_end_reg  <= frame_end;
        end
    end

    // Frame state: updated on every consumed byte, rearmed on the end-marked one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            still_ok_reg     <= 1'b1;
            captured_mac_reg <= '0;
        end
        else if (advance)
        begin
            if (in_end_reg)
            begin
                byte_index_reg   <= '0;
                still_ok_reg     <= 1'b1;
                captured_mac_reg <= '0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                still_ok_reg     <= still_ok_next;
                captured_mac_reg <= captured_mac_next;
            end
        end
    end

    // Result register: loaded by an end-marked byte, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && in_end_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_end_reg)
        begin
            res_matched_reg <= frame_ok;
            res_mac_reg     <= frame_ok ? captured_mac_next : '0;
        end
    end

    assign result_valid  = res_valid_reg;
    assign reply_matched = res_matched_reg;
    assign sender_mac    = res_mac_reg;

    // The input stalls only behind an end-marked byte that cannot reach a full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !frame_ready |-> (in_valid_reg && in_end_reg && res_valid_reg && !result_ready))
        else $error("input stalled without a pending result");

    // Every consumed end-marked byte rearms the frame state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_end_reg) |=> (byte_index_reg == '0 && still_ok_reg
                                     && captured_mac_reg == '0))
        else $error("frame state not rearmed after frame end");

    // A non-matching result never carries a sender address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !reply_matched) |-> (sender_mac == '0))
        else $error("sender address given for a non-matching frame");

    // The byte position saturates inside a long frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_end_reg && byte_index_reg == arf_pkg::IDX_MAX)
            |=> (byte_index_reg == arf_pkg::IDX_MAX))
        else $error("byte position wrapped inside a frame");

endmodule

// File: sim/arp_reply_filter_test.sv
// Self-checking testbench for the ARP reply filter: byte-serial frames in, match results out.
`timescale 1ns / 100ps

module arp_reply_filter_test;

    // Tracks the filter's frame state from the accepted bytes and holds the results
    // that are still due from the block, oldest first.
    class reply_tracker;

        typedef struct packed {
            logic                      matched;
            logic [arf_pkg::MAC_W-1:0] mac;
        } reply_t;

        logic [arf_pkg::MAC_W-1:0] own_mac;
        logic [arf_pkg::IP_W-1:0]  target_ip;
        logic [arf_pkg::IDX_W-1:0] byte_pos;
        bit                        frame_ok;
        logic [arf_pkg::MAC_W-1:0] mac_shift;
        reply_t                    pending_replies[$];
        int                        mismatches;

        function new();
            own_mac    = '0;
            target_ip  = '0;
            mismatches = 0;
            rearm();
        endfunction

        function void rearm();
            byte_pos  = '0;
            frame_ok  = 1'b1;
            mac_shift = '0;
        endfunction

        function void write_reg(arf_pkg::cfg_index_t idx, logic [arf_pkg::CFG_W-1:0] value);
            case (idx)
                arf_pkg::REG_OWN_MAC:   own_mac   = value[arf_pkg::MAC_W-1:0];
                arf_pkg::REG_TARGET_IP: target_ip = value[arf_pkg::IP_W-1:0];
                default:                ;
            endcase
        endfunction

        // True when the byte at this frame position passes its check; positions
        // outside the checked fields always pass.
        function bit byte_conforms(logic [arf_pkg::IDX_W-1:0] pos, logic [7:0] b);
            if (pos == arf_pkg::ETYPE_AT)
                return b == arf_pkg::ETYPE_HI;
            if (pos == arf_pkg::ETYPE_LO_AT)
                return b == arf_pkg::ETYPE_LO;
            if (pos >= arf_pkg::ARP_AT && pos <= arf_pkg::ARP_LAST)
                return b == arf_pkg::HDR_FIXED[pos - arf_pkg::ARP_AT];
            if (pos >= arf_pkg::SIP_AT && pos <= arf_pkg::SIP_LAST)
                return b == target_ip[8 * (arf_pkg::SIP_LAST - pos) +: 8];
            if (pos >= arf_pkg::TMAC_AT && pos <= arf_pkg::TMAC_LAST)
                return b == own_mac[8 * (arf_pkg::TMAC_LAST - pos) +: 8];
            return 1'b1;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            reply_t r;
            bit     ok;
            if (!byte_conforms(byte_pos, b))
                frame_ok = 1'b0;
            if (byte_pos >= arf_pkg::SMAC_AT && byte_pos <= arf_pkg::SMAC_LAST)
                mac_shift = {mac_shift[arf_pkg::MAC_W-9:0], b};
            if (last)
            begin
                ok        = frame_ok && (byte_pos >= arf_pkg::MIN_LEN_LAST);
                r.matched = ok;
                r.mac     = ok ? mac_shift : '0;
                pending_replies.push_back(r);
                rearm();
            end
            else if (byte_pos != arf_pkg::IDX_MAX)
            begin
                byte_pos = byte_pos + 1'b1;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_reply(logic matched, logic [arf_pkg::MAC_W-1:0] mac);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                report_mismatch($sformatf("result with none due: matched=%0b mac=%h",
                                          matched, mac));
                return;
            end
            want = pending_replies.pop_front();
            if (matched !== want.matched)
                report_mismatch($sformatf("reply_matched %0b, wanted %0b",
                                          matched, want.matched));
            if (mac !== want.mac)
                report_mismatch($sformatf("sender_mac %h, wanted %h", mac, want.mac));
        endtask

    endclass

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_ITEMS     = 360;
    localparam int PHASES           = 6;
    localparam int MIN_PHASE_FRAMES = 1;
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 2000;

    logic                      clk;
    logic                      rst_n;
    logic                      frame_valid;
    logic                      frame_ready;
    logic [7:0]                frame_byte;
    logic                      frame_end;
    logic                      result_valid;
    logic                      result_ready;
    logic                      reply_matched;
    logic [arf_pkg::MAC_W-1:0] sender_mac;
    logic                      cfg_we;
    logic [0:0]                cfg_index;
    logic [arf_pkg::CFG_W-1:0] cfg_data;

    reply_tracker sb;

    // Stimulus-side copy of the configuration, used to build frames that match it.
    logic [arf_pkg::MAC_W-1:0] cur_mac;
    logic [arf_pkg::IP_W-1:0]  cur_ip;
    logic [7:0]                frame_buf[$];
    int                        bytes_sent;
    int                        frames_sent;
    // Idle switches for both sides, and a one-shot request for a long result stall.
    bit                        tx_idle;
    bit                        rx_idle;
    int                        hold_req;

    arp_reply_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_valid),
        .frame_ready   (frame_ready),
        .frame_byte    (frame_byte),
        .frame_end     (frame_end),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .reply_matched (reply_matched),
        .sender_mac    (sender_mac),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [arf_pkg::MAC_W-1:0] random_mac();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[arf_pkg::MAC_W-1:0];
    endfunction

    // Builds a well-formed ARP reply from the current configuration, cut to len bytes.
    // Destination, source, target IP and padding are random since the block ignores them.
    function automatic void build_reply(int len, logic [arf_pkg::MAC_W-1:0] smac);
        logic [7:0] b;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            if (i == arf_pkg::ETYPE_AT)
                b = arf_pkg::ETYPE_HI;
            else if (i == arf_pkg::ETYPE_LO_AT)
                b = arf_pkg::ETYPE_LO;
            else if (i >= arf_pkg::ARP_AT && i <= arf_pkg::ARP_LAST)
                b = arf_pkg::HDR_FIXED[i - arf_pkg::ARP_AT];
            else if (i >= arf_pkg::SMAC_AT && i <= arf_pkg::SMAC_LAST)
                b = smac[8 * (arf_pkg::SMAC_LAST - i) +: 8];
            else if (i >= arf_pkg::SIP_AT && i <= arf_pkg::SIP_LAST)
                b = cur_ip[8 * (arf_pkg::SIP_LAST - i) +: 8];
            else if (i >= arf_pkg::TMAC_AT && i <= arf_pkg::TMAC_LAST)
                b = cur_mac[8 * (arf_pkg::TMAC_LAST - i) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            frame_buf.push_back(b);
        end
    endfunction

    // Sends frame_buf as one frame. Each task call starts and ends on a clock edge, with
    // frame_valid left high after the last byte so that a following frame can go out
    // back to back; whoever stops sending lowers it.
    task automatic send_frame();
        int gap;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            gap = tx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                frame_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            frame_valid <= 1'b1;
            frame_byte  <= frame_buf[i];
            frame_end   <= (i == frame_buf.size() - 1);
            do @(posedge clk); while (frame_ready !== 1'b1);
            sb.take_byte(frame_buf[i], i == frame_buf.size() - 1);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    // A reply of len bytes with, when bad_pos lies inside the frame, that one byte altered.
    task automatic send_reply(int len, logic [arf_pkg::MAC_W-1:0] smac, int bad_pos);
        logic [7:0] flip;
        flip = 8'($urandom_range(1, 255));
        build_reply(len, smac);
        if (bad_pos >= 0 && bad_pos < len)
            frame_buf[bad_pos] = frame_buf[bad_pos] ^ flip;
        send_frame();
    endtask

    // Stops offering bytes and waits until every due result has been taken, then lets
    // the pipeline run empty before anything else changes.
    task automatic settle();
        frame_valid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive cycles. The target IP write carries junk in
    // the upper bits, which the block has to drop.
    task automatic set_config(logic [arf_pkg::MAC_W-1:0] mac, logic [arf_pkg::IP_W-1:0] ip);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        cfg_we    <= 1'b1;
        cfg_index <= arf_pkg::REG_OWN_MAC;
        cfg_data  <= mac;
        @(posedge clk);
        sb.write_reg(arf_pkg::REG_OWN_MAC, mac);
        cfg_index <= arf_pkg::REG_TARGET_IP;
        cfg_data  <= {junk, ip};
        @(posedge clk);
        sb.write_reg(arf_pkg::REG_TARGET_IP, {junk, ip});
        cfg_we  <= 1'b0;
        cur_mac = mac;
        cur_ip  = ip;
    endtask

    // Result side: waits a random number of cycles before each item, or a long stretch
    // when asked, so the filter's output register fills and the input stalls.
    initial
    begin : result_sink
        int stall;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            sb.check_reply(reply_matched, sender_mac);
        end
    end

    // Ends the run when no handshake or register write happens for too long.
    initial
    begin : stall_watch
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((frame_valid && frame_ready) || (result_valid && result_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("arp_reply_filter_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                        pick;
        int                        len;
        int                        bad;
        int                        byte_goal;
        int                        frame_goal;
        int                        base_bytes;
        int                        base_frames;
        logic [arf_pkg::MAC_W-1:0] smac;

        sb          = new();
        cur_mac     = '0;
        cur_ip      = '0;
        bytes_sent  = 0;
        frames_sent = 0;
        hold_req    = 0;
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;

        rst_n       <= 1'b0;
        frame_valid <= 1'b0;
        frame_byte  <= '0;
        frame_end   <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= arf_pkg::REG_OWN_MAC;
        cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames. The first one relies on both registers being zero after reset.
        send_reply(38, random_mac(), -1);
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_config(48'h02_11_22_33_44_55, 32'hC0_A8_01_07);
        send_reply(38, {arf_pkg::MAC_W{1'b1}}, -1);   // shortest frame that can match
        send_reply(37, random_mac(), -1);             // one byte too short
        send_reply(1, random_mac(), -1);              // end mark on the very first byte
        send_reply(100, '0, -1);                      // byte index saturates, then the end mark
        send_reply(63, random_mac(), -1);
        send_reply(64, random_mac(), -1);
        send_reply(40, random_mac(), arf_pkg::ETYPE_AT);
        send_reply(40, random_mac(), arf_pkg::ETYPE_LO_AT);
        send_reply(40, random_mac(), arf_pkg::ARP_LAST); // operation is not a reply
        send_reply(40, random_mac(), arf_pkg::SIP_LAST);
        send_reply(40, random_mac(), arf_pkg::TMAC_AT);
        send_reply(40, random_mac(), arf_pkg::TMAC_LAST);
        // Target IP, padding and the sender MAC itself are not checked.
        send_reply(45, random_mac(), 38);
        send_reply(45, random_mac(), arf_pkg::SMAC_AT);
        settle();
        set_config({arf_pkg::MAC_W{1'b1}}, {arf_pkg::IP_W{1'b1}});
        send_reply(38, random_mac(), -1);
        send_reply(39, random_mac(), arf_pkg::SIP_AT);
        settle();

        // Random part: each phase gets its own configuration and idle pattern. Most frames
        // are replies built for the current configuration, a share of them with one byte
        // altered; the rest are cut-off replies and plain noise.
        base_bytes  = bytes_sent;
        base_frames = frames_sent;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:       set_config('0, {arf_pkg::IP_W{1'b1}});
                2:       set_config({arf_pkg::MAC_W{1'b1}}, '0);
                default: set_config(random_mac(), $urandom());
            endcase
            tx_idle = (phase % 4 == 0) || (phase % 4 == 1);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 2);

            // Long result stall while short frames keep coming, so the input backs up.
            if (phase == 3)
            begin
                hold_req = HOLD_CYCLES;
                repeat (30)
                begin
                    build_reply($urandom_range(1, 3), random_mac());
                    send_frame();
                end
            end

            byte_goal  = base_bytes + (phase + 1) * RANDOM_ITEMS / PHASES;
            frame_goal = base_frames + (phase + 1) * MIN_PHASE_FRAMES;
            while (bytes_sent < byte_goal || frames_sent < frame_goal)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 19))
                    0:       smac = '0;
                    1:       smac = {arf_pkg::MAC_W{1'b1}};
                    default: smac = random_mac();
                endcase
                if (pick < 55)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 100)
                                                      : $urandom_range(38, 64);
                    if ($urandom_range(0, 99) < 40)
                        bad = $urandom_range(arf_pkg::ETYPE_AT, arf_pkg::TMAC_LAST);
                    else if ($urandom_range(0, 9) == 0)
                        bad = $urandom_range(0, len - 1);
                    else
                        bad = -1;
                    send_reply(len, smac, bad);
                end
                else if (pick < 75)
                begin
                    send_reply($urandom_range(1, 37), smac, -1);
                end
                else
                begin
                    len = $urandom_range(1, 70);
                    frame_buf.delete();
                    repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));
                    send_frame();
                end
                // Now and then the sender stops until every result has come back.
                if ($urandom_range(0, 49) == 0)
                    settle();
            end
            settle();
        end

        if (sb.mismatches == 0 && sb.pending_replies.size() == 0)
            $display("arp_reply_filter_test: PASS");
        else
            $display("arp_reply_filter_test: FAIL");
        $finish;
    end

endmodule

// File: arp_reply_filter.f
sv/arf_pkg.sv
sv/arp_reply_filter.sv
sim/arp_reply_filter_test.sv
